// ===== design/lscd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LRU slot cache directory package
// Shared constants and command codes for the slot directory.
// ---------------------------------------------------------------------------
package lscd_pkg;
	localparam int SLOTS_DEF = 64;
	localparam int KEYS_DEF  = 4096;

	typedef enum logic [1:0] {
		CMD_ACCESS = 2'd0,
		CMD_TOUCH  = 2'd1,
		CMD_PROBE  = 2'd2,
		CMD_ENSURE = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;
	localparam logic [0:0] REG_EXPERTS      = 1'b1;
endpackage
`default_nettype wire

// ===== design/lru_slot_cache_directory_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An item whose key is neither restamped nor installed (probe, bad key, touch miss, ensure hit)
// passes READ, DEC and OUT; a restamping hit adds WRITE; a miss that installs also scans
// n slots in SCAN, where n is slots_in_use held to 1..SLOTS, then passes EVICT, DROP and WRITE.
// One item at a time: the single stamp comparator scans one slot per cycle, and the next
// item is taken only after the result transfer, once the block is back in IDLE.
// Reset clears control state, counters and slot valid bits; a clearing pass then sweeps
// the whole key store before the first item is taken.
// ---------------------------------------------------------------------------
// LRU slot cache directory
// Fully associative slot directory with timestamp LRU replacement.
// ---------------------------------------------------------------------------
module lru_slot_cache_directory_core
	import lscd_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int KEYS  = KEYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  layer_index,
	input  wire logic [7:0]  expert_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic [5:0]       slot,
	output logic             fetch_needed,
	output logic             evicted,
	output logic [11:0]      evicted_key,
	output logic             bad_key,
	output logic [31:0]      key_count,
	output logic [31:0]      hits_total,
	output logic [31:0]      misses_total,
	output logic [31:0]      evictions_total,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data
);
	localparam int SW = $clog2(SLOTS);
	localparam int KW = $clog2(KEYS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = 15;  // product width, 6 + 9 bits

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_READ  = 9'b000000100,
		ST_DEC   = 9'b000001000,
		ST_SCAN  = 9'b000010000,
		ST_EVICT = 9'b000100000,
		ST_DROP  = 9'b001000000,
		ST_WRITE = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [KW-1:0]  clr_q;
	logic [6:0]     slots_cfg_q;
	logic [8:0]     epl_cfg_q;
	logic [1:0]     cmd_q;
	logic [PW-1:0]  key_full_q;
	logic [KW-1:0]  key_q;
	logic           bad_q;

	// Key store: present bit, slot and count packed in one word.
	logic [SW+32:0] kmem [KEYS];
	logic [SW+32:0] krd_q;
	logic [63:0]    stamp_mem [SLOTS];
	logic [63:0]    srd_q;
	logic [KW-1:0]  owner_mem [SLOTS];
	logic [KW-1:0]  ord_q;
	logic           sv_rd_q;
	logic [SLOTS-1:0] svalid_q;

	logic [63:0]    clock_q;
	logic [31:0]    hitc_q, missc_q, evc_q;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  n_q;
	logic [63:0]    best_q;
	logic [SW-1:0]  victim_q;
	logic [KW-1:0]  vowner_q;
	logic           scan_first_q;

	logic           r_hit_q, r_fetch_q, r_ev_q;
	logic [SW-1:0]  r_slot_q;
	logic [KW-1:0]  r_evkey_q;
	logic [31:0]    r_kc_q;

	logic           present;
	logic [SW-1:0]  cur_slot;
	logic [31:0]    cur_cnt, inc_cnt;
	logic [SW-1:0]  scan_idx;
	logic [63:0]    scan_stamp;

	assign present  = krd_q[SW+32];
	assign cur_slot = krd_q[SW+31:32];
	assign cur_cnt  = krd_q[31:0];
	assign inc_cnt  = (cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1;
	assign scan_idx = scan_q[SW-1:0];
	// A slot that never had an owner has never been stamped and reads as zero.
	assign scan_stamp = sv_rd_q ? srd_q : 64'd0;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= 7'd64;
			epl_cfg_q   <= 9'd128;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SLOTS_IN_USE) slots_cfg_q <= cfg_data[6:0];
			else epl_cfg_q <= cfg_data;
		end
	end

	// Key store port: one access per cycle, read data registered.
	logic           kwe;
	logic [KW-1:0]  kaddr;
	logic [SW+32:0] kwdata;
	logic [63:0]    sstamp_new;
	logic           swe;
	logic [SW-1:0]  saddr;

	always_comb begin
		kwe    = 1'b0;
		kaddr  = key_q;
		kwdata = '0;
		swe    = 1'b0;
		saddr  = scan_idx;
		// The clock has already advanced when the stamp is written.
		sstamp_new = clock_q;
		case (state_q)
			ST_CLEAR: begin
				kwe = 1'b1;
				kaddr = clr_q;
			end
			ST_EVICT: begin
				kaddr = vowner_q;
			end
			ST_DROP: begin
				// The evicted owner loses residency but keeps its count.
				kaddr = vowner_q;
				kwe = svalid_q[victim_q];
				kwdata = {1'b0, {SW{1'b0}}, krd_q[31:0]};
			end
			ST_WRITE: begin
				kwe = 1'b1;
				if (r_fetch_q) begin
					kwdata = {1'b1, victim_q, r_kc_q};
					saddr = victim_q;
					swe = 1'b1;
				end else begin
					kwdata = {1'b1, cur_slot, r_kc_q};
					saddr = cur_slot;
					swe = (cmd_q == CMD_ACCESS) || (cmd_q == CMD_TOUCH);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (kwe) kmem[kaddr] <= kwdata;
		krd_q <= kmem[kaddr];
		if (swe) stamp_mem[saddr] <= sstamp_new;
		srd_q <= stamp_mem[saddr];
		if (state_q == ST_WRITE && r_fetch_q) owner_mem[victim_q] <= key_q;
		ord_q <= owner_mem[saddr];
		sv_rd_q <= svalid_q[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			svalid_q <= '0;
			clock_q  <= '0;
			hitc_q   <= '0;
			missc_q  <= '0;
			evc_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == KW'(KEYS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_DEC;
				ST_DEC: begin
					r_hit_q   <= 1'b0;
					r_slot_q  <= '0;
					r_fetch_q <= 1'b0;
					r_ev_q    <= 1'b0;
					r_evkey_q <= '0;
					r_kc_q    <= '0;
					state_q   <= ST_OUT;
					if (!bad_q) begin
						r_hit_q <= present;
						r_kc_q  <= cur_cnt;
						if (present) begin
							r_slot_q <= cur_slot;
							if (cmd_q == CMD_ACCESS || cmd_q == CMD_TOUCH) begin
								r_kc_q  <= inc_cnt;
								hitc_q  <= (hitc_q == 32'hFFFF_FFFF) ? hitc_q
									: hitc_q + 32'd1;
								clock_q <= clock_q + 64'd1;
								state_q <= ST_WRITE;
							end
						end else if (cmd_q == CMD_ACCESS || cmd_q == CMD_ENSURE) begin
							if (cmd_q == CMD_ACCESS) r_kc_q <= inc_cnt;
							missc_q <= (missc_q == 32'hFFFF_FFFF) ? missc_q
								: missc_q + 32'd1;
							r_fetch_q <= 1'b1;
							scan_q    <= '0;
							scan_first_q <= 1'b1;
							victim_q  <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// The read data holds the slot addressed last cycle.
					scan_q <= scan_q + 1'b1;
					if (scan_q != '0) begin
						if (scan_first_q || scan_stamp < best_q) begin
							best_q   <= scan_stamp;
							victim_q <= SW'(scan_q - 1'b1);
							vowner_q <= ord_q;
						end
						scan_first_q <= 1'b0;
						if (scan_q == n_q) state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (svalid_q[victim_q]) begin
						r_ev_q    <= 1'b1;
						r_evkey_q <= vowner_q;
						evc_q <= (evc_q == 32'hFFFF_FFFF) ? evc_q : evc_q + 32'd1;
					end
					clock_q <= clock_q + 64'd1;
					r_slot_q <= victim_q;
					state_q <= ST_DROP;
				end
				ST_DROP: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (r_fetch_q) svalid_q[victim_q] <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input capture and key forming.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q      <= command;
			key_full_q <= PW'(layer_index) * PW'(epl_cfg_q) + PW'(expert_index);
		end
		if (state_q == ST_READ) begin
			bad_q <= (32'(key_full_q) >= 32'(KEYS));
		end
		if (state_q == ST_DEC) begin
			if (slots_cfg_q == 7'd0) n_q <= CW'(1);
			else if ({25'd0, slots_cfg_q} > SLOTS) n_q <= CW'(SLOTS);
			else n_q <= CW'(slots_cfg_q);
		end
	end

	assign key_q = KW'(key_full_q);

	assign hit             = r_hit_q;
	assign slot            = 6'(r_slot_q);
	assign fetch_needed    = r_fetch_q;
	assign evicted         = r_ev_q;
	assign evicted_key     = 12'(r_evkey_q);
	assign bad_key         = bad_q;
	assign key_count       = r_kc_q;
	assign hits_total      = hitc_q;
	assign misses_total    = missc_q;
	assign evictions_total = evc_q;
endmodule
`default_nettype wire
